// ===== sv/ray_box_slab_test_defines.svh =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_defines
// assertion macros shared by the ray box slab test rtl
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// implication checked on every edge outside reset
`define RBST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// types and constants for the ray box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int QBITS   = 32;
    localparam int DIV_LAT = QBITS + 2;
    localparam int NAXES   = 3;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic signed [31:0] T_POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_NEG_MAX = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        t_entry;
        logic signed [31:0] t_exit;
        logic [30:0]        hit_distance;
    } result_t;

    // what one axis lane hands to the merge
    typedef struct packed {
        logic               par;
        logic               outside;
        logic signed [31:0] ta;
        logic signed [31:0] tb;
    } lane_res_t;

endpackage

// ===== sv/rbst_ray_if.sv =====
// ----------------------------------------------------------------------------
// rbst_ray_if
// valid/ready channel carrying one ray
// ----------------------------------------------------------------------------
interface rbst_ray_if;
    logic          valid;
    logic          ready;
    rbst_pkg::ray_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rbst_res_if.sv =====
// ----------------------------------------------------------------------------
// rbst_res_if
// valid/ready channel carrying one test result
// ----------------------------------------------------------------------------
interface rbst_res_if;
    logic             valid;
    logic             ready;
    rbst_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div
// pipelined restoring divider, one quotient bit per stage, saturating to 32 bits
// ----------------------------------------------------------------------------
module rbst_div
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [33+FRAC_BITS-1:0]  num_mag,
    input  logic [31:0]              den,
    input  logic                     neg,
    output logic signed [31:0]       quo
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int HW = NW - QBITS;

    logic [31:0]       rem_reg [0:QBITS];
    logic [31:0]       low_reg [0:QBITS];
    logic [31:0]       den_reg [0:QBITS];
    logic [QBITS-1:0]  q_reg   [0:QBITS];
    logic              ovf_reg [0:QBITS];
    logic              neg_reg [0:QBITS];
    logic signed [31:0] quo_reg;
    logic [HW-1:0]     num_hi;

    assign num_hi = num_mag[NW-1:QBITS];

    // quotient of 2^32 or more means saturation regardless of sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {{(32-HW){1'b0}}, num_hi};
            low_reg[0] <= num_mag[QBITS-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({{(32-HW){1'b0}}, num_hi} >= den);
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= QBITS; k++)
    begin : g_stage
        logic [32:0] trial;
        logic        ge;
        logic [32:0] diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][31]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[31:0] : trial[31:0];
                low_reg[k] <= {low_reg[k-1][30:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QBITS-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[QBITS])
            begin
                if (ovf_reg[QBITS] || (q_reg[QBITS] > 32'h8000_0000))
                    quo_reg <= T_NEG_MAX;
                else
                    quo_reg <= -$signed(q_reg[QBITS]);
            end
            else
            begin
                if (ovf_reg[QBITS] || q_reg[QBITS][31])
                    quo_reg <= T_POS_MAX;
                else
                    quo_reg <= $signed(q_reg[QBITS]);
            end
        end
    end

    assign quo = quo_reg;

endmodule

// ===== sv/rbst_lane.sv =====
// ----------------------------------------------------------------------------
// rbst_lane
// one axis: both slab parameters through two dividers, parallel case alongside
// ----------------------------------------------------------------------------
module rbst_lane
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    input  logic signed [31:0] org,
    input  logic signed [31:0] dir,
    output lane_res_t          res
);

    logic signed [32:0] d_lo;
    logic signed [32:0] d_hi;
    logic [32:0]        m_lo;
    logic [32:0]        m_hi;
    logic [31:0]        dir_mag;
    logic               par;
    logic               outside;
    logic               par_reg [0:DIV_LAT-1];
    logic               out_reg [0:DIV_LAT-1];
    logic signed [31:0] ta;
    logic signed [31:0] tb;

    assign d_lo    = 33'(lo) - 33'(org);
    assign d_hi    = 33'(hi) - 33'(org);
    assign m_lo    = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
    assign m_hi    = d_hi[32] ? 33'(-d_hi) : 33'(d_hi);
    assign dir_mag = dir[31] ? 32'(-dir) : 32'(dir);
    assign par     = (dir == '0);
    assign outside = (org < lo) || (org > hi);

    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
        .clk     (clk),
        .en      (en),
        .num_mag ({m_lo, {FRAC_BITS{1'b0}}}),
        .den     (dir_mag),
        .neg     (d_lo[32] ^ dir[31]),
        .quo     (ta)
    );

    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
        .clk     (clk),
        .en      (en),
        .num_mag ({m_hi, {FRAC_BITS{1'b0}}}),
        .den     (dir_mag),
        .neg     (d_hi[32] ^ dir[31]),
        .quo     (tb)
    );

    // parallel-axis decision rides along with the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg[0] <= par;
            out_reg[0] <= outside;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                par_reg[k] <= par_reg[k-1];
                out_reg[k] <= out_reg[k-1];
            end
        end
    end

    assign res.par     = par_reg[DIV_LAT-1];
    assign res.outside = out_reg[DIV_LAT-1];
    assign res.ta      = ta;
    assign res.tb      = tb;

endmodule

// ===== sv/rbst_merge.sv =====
// ----------------------------------------------------------------------------
// rbst_merge
// folds the three axis lanes in x, y, z order into the final hit result
// ----------------------------------------------------------------------------
module rbst_merge
    import rbst_pkg::*;
(
    input  lane_res_t lanes [0:NAXES-1],
    output result_t   res
);

    always_comb
    begin
        logic signed [31:0] t_in;
        logic signed [31:0] t_out;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               miss;

        t_in  = '0;
        t_out = T_POS_MAX;
        miss  = 1'b0;
        for (int i = 0; i < NAXES; i++)
        begin
            a = (lanes[i].ta > lanes[i].tb) ? lanes[i].tb : lanes[i].ta;
            b = (lanes[i].ta > lanes[i].tb) ? lanes[i].ta : lanes[i].tb;
            if (!miss)
            begin
                if (lanes[i].par)
                begin
                    miss = lanes[i].outside;
                end
                else
                begin
                    if (a > t_in)
                        t_in = a;
                    if (b < t_out)
                        t_out = b;
                    miss = (t_in > t_out);
                end
            end
        end
        if (t_out < 0)
            miss = 1'b1;

        res.hit          = !miss;
        res.t_entry      = t_in[30:0];
        res.t_exit       = t_out;
        res.hit_distance = miss ? '0 : t_in[30:0];
    end

endmodule

// ===== sv/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// ray against axis-aligned box, slab method in signed fixed point
// ----------------------------------------------------------------------------
// rays come in on the ray channel, one result leaves on the res channel for
// each ray, in order. the user must write the box corners through cfg_we,
// cfg_index, cfg_data only while no ray is in flight; indexes above five are dropped.
// three axis lanes each run two pipelined dividers (one quotient bit per
// stage), then a merge folds the axes and fills the output register.
// the block itself does not enforce that rule on cfg writes.
// throughput: one ray per cycle while the result channel is not stalled.
// when the receiver stalls with a result held, the whole pipeline freezes and
// ray.ready drops until that beat is taken; bubbles do not hold it back.
// reset clears the valid pipeline and sets all box corners to zero.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_defines.svh"

module ray_box_slab_test
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    rbst_ray_if.sink     ray,
    rbst_res_if.source   res,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic signed [31:0] lo_reg [0:NAXES-1];
    logic signed [31:0] hi_reg [0:NAXES-1];
    logic               vld_reg [0:DIV_LAT-1];
    logic               res_valid_reg;
    result_t            res_data_reg;
    result_t            merged;
    lane_res_t          lanes [0:NAXES-1];
    logic               en;
    logic signed [31:0] org [0:NAXES-1];
    logic signed [31:0] dir [0:NAXES-1];

    assign en        = !res_valid_reg || res.ready;
    assign ray.ready = en;

    assign org[0] = ray.data.origin_x;
    assign org[1] = ray.data.origin_y;
    assign org[2] = ray.data.origin_z;
    assign dir[0] = ray.data.dir_x;
    assign dir[1] = ray.data.dir_y;
    assign dir[2] = ray.data.dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAXES; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_X: lo_reg[0] <= cfg_data;
                REG_MIN_Y: lo_reg[1] <= cfg_data;
                REG_MIN_Z: lo_reg[2] <= cfg_data;
                REG_MAX_X: hi_reg[0] <= cfg_data;
                REG_MAX_Y: hi_reg[1] <= cfg_data;
                REG_MAX_Z: hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar a = 0; a < NAXES; a++)
    begin : g_lane
        rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk (clk),
            .en  (en),
            .lo  (lo_reg[a]),
            .hi  (hi_reg[a]),
            .org (org[a]),
            .dir (dir[a]),
            .res (lanes[a])
        );
    end

    rbst_merge u_merge (
        .lanes (lanes),
        .res   (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                vld_reg[k] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= ray.valid;
            for (int k = 1; k < DIV_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
            res_valid_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_data_reg <= merged;
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    `RBST_ASSERT_IMP(a_hit_order, res.valid && res.data.hit,
        $signed({1'b0, res.data.t_entry}) <= res.data.t_exit, "hit with entry past exit")
    `RBST_ASSERT_IMP(a_dist, res.valid,
        res.data.hit_distance == (res.data.hit ? res.data.t_entry : 31'd0),
        "hit distance disagrees with entry")
    `RBST_ASSERT_IMP(a_stall, res.valid && !res.ready, !ray.ready,
        "ray taken while result stalled")
    `RBST_ASSERT_NEXT(a_hold, res.valid && !res.ready, res.valid,
        "result dropped while stalled")

endmodule
